/* hdl/b64sd_pkg.sv */
// Shared types and character codes for the base64 stream decoder.
package b64sd_pkg;

    localparam int CHAR_W    = 8;
    localparam int SEXTET_W  = 6;
    localparam int PEND_W    = 3;
    localparam int TDATA_W   = 8;
    localparam int M_TUSER_W = 2;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PAD   = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_D0    = 8'h30;
    localparam logic [CHAR_W-1:0] CH_D9    = 8'h39;

    // Bit positions inside m_tuser
    localparam int TU_BYTE_VALID = 0;
    localparam int TU_STATUS     = 1;

    typedef enum logic [1:0] {
        KIND_BLANK,
        KIND_PAD,
        KIND_SEXTET,
        KIND_INVALID
    } char_kind_t;

    typedef struct packed {
        char_kind_t          kind;
        logic [SEXTET_W-1:0] sextet;
    } char_class_t;

endpackage

/* hdl/b64sd_classify.sv */
// Character classifier: sorts one byte into blank, pad, alphabet or invalid.
module b64sd_classify (
    input  logic [b64sd_pkg::CHAR_W-1:0] char_in,
    output b64sd_pkg::char_class_t       class_out
);
    import b64sd_pkg::*;

    logic [CHAR_W-1:0] offset;

    always_comb begin
        offset           = '0;
        class_out.kind   = KIND_INVALID;
        class_out.sextet = '0;
        case (char_in) inside
            CH_SPACE, [CH_TAB:CH_CR]: begin
                class_out.kind = KIND_BLANK;
            end
            CH_PAD: begin
                class_out.kind = KIND_PAD;
            end
            [CH_UA:CH_UZ]: begin
                offset           = char_in - CH_UA;
                class_out.kind   = KIND_SEXTET;
                class_out.sextet = offset[SEXTET_W-1:0];
            end
            [CH_LA:CH_LZ]: begin
                // 'a' maps to 26
                offset           = char_in - CH_LA + 8'd26;
                class_out.kind   = KIND_SEXTET;
                class_out.sextet = offset[SEXTET_W-1:0];
            end
            [CH_D0:CH_D9]: begin
                // '0' maps to 52
                offset           = char_in - CH_D0 + 8'd52;
                class_out.kind   = KIND_SEXTET;
                class_out.sextet = offset[SEXTET_W-1:0];
            end
            CH_PLUS: begin
                class_out.kind   = KIND_SEXTET;
                class_out.sextet = 6'd62;
            end
            CH_SLASH: begin
                class_out.kind   = KIND_SEXTET;
                class_out.sextet = 6'd63;
            end
            default: begin
                class_out.kind = KIND_INVALID;
            end
        endcase
    end

endmodule

/* hdl/base64_stream_decoder.sv */
// Base64 stream decoder: one character word in, one result word out.
//
// Input channel s_*: one base64 character per word in s_tdata, s_tlast marks
// the final character of a message. Output channel m_*: one result word per
// input word. m_tdata carries the decoded byte (zero when none), m_tuser[0]
// flags that the word completed a byte, m_tuser[1] is the sticky error
// status of the message, m_tlast echoes s_tlast so the status on that word
// is the final verdict. On an error the receiver drops the bytes it already
// took for the message.
//
// Pipeline: the accepting edge loads the input register, a later advance
// loads the decoded result into the output register and raises m_tvalid.
// Throughput is one word per cycle while the receiver keeps m_tready high;
// the accumulator update is the only feedback path.
// Reset (aresetn low, synchronous) empties both registers and clears the
// accumulator, pending count, pad and error state. When the receiver stalls, the output
// word holds, one more word waits in the input register, then s_tready drops.
module base64_stream_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [b64sd_pkg::TDATA_W-1:0]    s_tdata,   // [7:0] in_char
    input  logic                             s_tlast,   // last_char
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [b64sd_pkg::TDATA_W-1:0]    m_tdata,   // [7:0] out_byte
    output logic [b64sd_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] byte_valid, [1] status
    output logic                             m_tlast    // end_of_message
);
    import b64sd_pkg::*;

    // Input stage
    logic                in_valid_reg;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_last_reg;

    // Decoder state
    logic [SEXTET_W-1:0] acc_reg,     acc_next;
    logic [PEND_W-1:0]   pend_reg,    pend_next;
    logic                pad_reg,     pad_next;
    logic                err_reg,     err_next;

    // Output stage
    logic                m_valid_reg;
    logic [TDATA_W-1:0]  out_byte_reg, out_byte_next;
    logic                byte_valid_reg, byte_valid_next;
    logic                status_reg;
    logic                last_reg;

    char_class_t         cls;
    logic                advance;
    logic [2*SEXTET_W-1:0] acc_wide;
    logic [PEND_W-1:0]   rest;

    b64sd_classify u_classify (
        .char_in   (in_char_reg),
        .class_out (cls)
    );

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign acc_wide = {acc_reg, cls.sextet};
    assign rest     = pend_reg - PEND_W'(2);

    always_comb begin
        acc_next        = acc_reg;
        pend_next       = pend_reg;
        pad_next        = pad_reg;
        err_next        = err_reg;
        out_byte_next   = '0;
        byte_valid_next = 1'b0;
        if (!pad_reg && !err_reg) begin
            case (cls.kind)
                KIND_PAD: begin
                    pad_next = 1'b1;
                end
                KIND_INVALID: begin
                    err_next = 1'b1;
                end
                KIND_SEXTET: begin
                    if (pend_reg == '0) begin
                        acc_next  = cls.sextet;
                        pend_next = PEND_W'(6);
                    end else begin
                        // emit top eight bits, keep the low rest bits
                        byte_valid_next = 1'b1;
                        pend_next       = rest;
                        case (rest)
                            PEND_W'(0): begin
                                out_byte_next = acc_wide[7:0];
                                acc_next      = '0;
                            end
                            PEND_W'(2): begin
                                out_byte_next = acc_wide[9:2];
                                acc_next      = {4'b0, acc_wide[1:0]};
                            end
                            default: begin
                                out_byte_next = acc_wide[11:4];
                                acc_next      = {2'b0, acc_wide[3:0]};
                            end
                        endcase
                    end
                end
                default: begin
                    // whitespace: hold everything
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            acc_reg      <= '0;
            pend_reg     <= '0;
            pad_reg      <= 1'b0;
            err_reg      <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (advance) begin
                if (in_last_reg) begin
                    // message done: clear for the next one
                    acc_reg  <= '0;
                    pend_reg <= '0;
                    pad_reg  <= 1'b0;
                    err_reg  <= 1'b0;
                end else begin
                    acc_reg  <= acc_next;
                    pend_reg <= pend_next;
                    pad_reg  <= pad_next;
                    err_reg  <= err_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_byte_reg   <= out_byte_next;
            byte_valid_reg <= byte_valid_next;
            status_reg     <= err_next;
            last_reg       <= in_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {status_reg, byte_valid_reg};
    assign m_tlast  = last_reg;

endmodule

/* hdl/b64sd_checker.sv */
// Port-level checks for the base64 stream decoder, bound to the top level.
module b64sd_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [b64sd_pkg::TDATA_W-1:0]    m_tdata,
    input logic [b64sd_pkg::M_TUSER_W-1:0]  m_tuser,
    input logic                             m_tlast
);
    import b64sd_pkg::*;

    // error seen on an earlier word of the current message
    logic err_open_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_open_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            err_open_reg <= m_tuser[TU_STATUS] && !m_tlast;
        end
    end

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_status_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && err_open_reg |-> m_tuser[TU_STATUS])
        else $error("error status cleared inside a message");

    a_no_byte_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TU_STATUS] |-> !m_tuser[TU_BYTE_VALID])
        else $error("byte emitted after an error");

    a_zero_without_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TU_BYTE_VALID] |-> m_tdata == '0)
        else $error("nonzero data on a word without a byte");

    // both stages empty after reset, so the input side is open
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not empty right after reset");

endmodule

bind base64_stream_decoder b64sd_checker u_b64sd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* tb/sv/b64_decode_checker.sv */
`timescale 1ns / 1ps
// Checker for the base64 stream decoder: predicts every result word and compares.
module b64_decode_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [b64sd_pkg::TDATA_W-1:0]    s_tdata,   // [7:0] in_char
    input  logic                             s_tlast,   // last_char
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [b64sd_pkg::TDATA_W-1:0]    m_tdata,   // [7:0] out_byte
    input  logic [b64sd_pkg::M_TUSER_W-1:0]  m_tuser,   // [0] byte_valid, [1] status
    input  logic                             m_tlast,   // end_of_message
    output int                               mismatch_count,
    output int                               words_outstanding
);
    import b64sd_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       status;
        logic       end_of_msg;
    } decoded_word_t;

    decoded_word_t          decoded_q[$];
    logic [SEXTET_W-1:0]    acc_bits;
    logic [PEND_W-1:0]      pend_count;
    logic                   pad_seen;
    logic                   err_seen;
    int                     errors = 0;

    function automatic char_class_t classify(input logic [CHAR_W-1:0] ch);
        char_class_t cls;
        cls.sextet = '0;
        if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
            cls.kind = KIND_BLANK;
        end else if (ch == CH_PAD) begin
            cls.kind = KIND_PAD;
        end else if (ch >= CH_UA && ch <= CH_UZ) begin
            cls.kind   = KIND_SEXTET;
            cls.sextet = SEXTET_W'(ch - CH_UA);
        end else if (ch >= CH_LA && ch <= CH_LZ) begin
            cls.kind   = KIND_SEXTET;
            cls.sextet = SEXTET_W'(ch - CH_LA + 8'd26);
        end else if (ch >= CH_D0 && ch <= CH_D9) begin
            cls.kind   = KIND_SEXTET;
            cls.sextet = SEXTET_W'(ch - CH_D0 + 8'd52);
        end else if (ch == CH_PLUS) begin
            cls.kind   = KIND_SEXTET;
            cls.sextet = 6'd62;
        end else if (ch == CH_SLASH) begin
            cls.kind   = KIND_SEXTET;
            cls.sextet = 6'd63;
        end else begin
            cls.kind = KIND_INVALID;
        end
        return cls;
    endfunction

    // Advance the decoder state by one character and form its result word.
    task automatic decode_char(input logic [CHAR_W-1:0] ch, input logic last,
                               output decoded_word_t w);
        char_class_t  cls;
        logic [11:0]  acc;
        logic [3:0]   n;
        cls = classify(ch);
        w   = '0;
        if (!pad_seen && !err_seen) begin
            case (cls.kind)
                KIND_PAD:     pad_seen = 1'b1;
                KIND_INVALID: err_seen = 1'b1;
                KIND_SEXTET: begin
                    acc = {acc_bits, cls.sextet};
                    n   = 4'(pend_count) + 4'd6;
                    if (n >= 4'd8) begin
                        n            = n - 4'd8;
                        w.out_byte   = 8'(acc >> n);
                        w.byte_valid = 1'b1;
                    end
                    pend_count = n[PEND_W-1:0];
                    acc_bits   = SEXTET_W'(acc & ((12'd1 << n) - 12'd1));
                end
                default: ;
            endcase
        end
        w.status     = err_seen;
        w.end_of_msg = last;
        // clear for the next message
        if (last) begin
            acc_bits   = '0;
            pend_count = '0;
            pad_seen   = 1'b0;
            err_seen   = 1'b0;
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : watch_channels
        decoded_word_t want;
        if (!aresetn) begin
            acc_bits   = '0;
            pend_count = '0;
            pad_seen   = 1'b0;
            err_seen   = 1'b0;
            decoded_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast, want);
                decoded_q.insert(decoded_q.size(), want);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none, %s %0h user %0h last %0b",
                             $time, "actual byte", m_tdata, m_tuser, m_tlast);
                    errors++;
                end else begin
                    want = decoded_q.pop_front();
                    check_field("out_byte", want.out_byte, m_tdata);
                    check_field("byte_valid", want.byte_valid, m_tuser[TU_BYTE_VALID]);
                    check_field("status", want.status, m_tuser[TU_STATUS]);
                    check_field("end_of_message", want.end_of_msg, m_tlast);
                end
            end
        end
        mismatch_count    <= errors;
        words_outstanding <= decoded_q.size();
    end

endmodule

/* tb/sv/base64_stream_decoder_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the base64 stream decoder: clock, reset, stimulus and verdict.
module base64_stream_decoder_tb;
    import b64sd_pkg::*;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata  = '0;   // [7:0] in_char
    logic                   s_tlast  = 1'b0; // last_char
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;         // [7:0] out_byte
    logic [M_TUSER_W-1:0]   m_tuser;         // [0] byte_valid, [1] status
    logic                   m_tlast;         // end_of_message

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int chars_sent    = 0;
    int mismatch_count;
    int words_outstanding;

    base64_stream_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    b64_decode_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tlast           (s_tlast),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .m_tuser           (m_tuser),
        .m_tlast           (m_tlast),
        .mismatch_count    (mismatch_count),
        .words_outstanding (words_outstanding)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Call at a rising edge; returns at the edge that accepts the word.
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string txt, input logic last_at_end);
        for (int i = 0; i < txt.len(); i++) begin
            send_char(txt[i], last_at_end && (i == txt.len() - 1));
        end
    endtask

    // Hold the sender until every predicted word has come back.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (words_outstanding != 0) @(posedge aclk);
    endtask

    function automatic logic [CHAR_W-1:0] sextet_char(input logic [SEXTET_W-1:0] v);
        if (v < 26) return CH_UA + 8'(v);
        if (v < 52) return CH_LA + 8'(v - 26);
        if (v < 62) return CH_D0 + 8'(v - 52);
        return (v == 62) ? CH_PLUS : CH_SLASH;
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        int v;
        v = $urandom_range(5);
        return (v == 5) ? CH_SPACE : CH_TAB + 8'(v);
    endfunction

    function automatic logic [CHAR_W-1:0] noise_char();
        int r;
        r = $urandom_range(9);
        if (r < 5) return sextet_char(SEXTET_W'($urandom_range(63)));
        if (r < 7) return blank_char();
        if (r == 7) return CH_PAD;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed encoded payloads, the rest random noise.
    task automatic send_random_message();
        logic [CHAR_W-1:0] chars[$];
        logic [23:0]       grp;
        int                nbytes;
        int                left;
        if ($urandom_range(99) < 70) begin
            nbytes = $urandom_range(12);
            for (int i = 0; i < nbytes; i += 3) begin
                left = nbytes - i;
                grp  = 24'($urandom);
                chars.insert(chars.size(), sextet_char(grp[23:18]));
                chars.insert(chars.size(), sextet_char(grp[17:12]));
                if (left > 1) chars.insert(chars.size(), sextet_char(grp[11:6]));
                if (left > 2) chars.insert(chars.size(), sextet_char(grp[5:0]));
            end
            // drop the padding now and then
            if ($urandom_range(3) != 0) begin
                while (chars.size() % 4 != 0) chars.insert(chars.size(), CH_PAD);
            end
            if ($urandom_range(9) == 0) chars.insert(chars.size(), 8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 10)) chars.insert(chars.size(), noise_char());
        end
        if (chars.size() == 0) chars.insert(chars.size(), blank_char());
        foreach (chars[i]) begin
            if ($urandom_range(9) == 0) send_char(blank_char(), 1'b0);
            send_char(chars[i], i == chars.size() - 1);
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 24;
        recv_idle_pct <= 82;

        // plain group, decodes to three bytes
        send_text("TWFu", 1'b1);
        // blanks, top sextets, pad, then chars ignored after pad
        send_char(CH_SPACE, 1'b0);
        send_char(CH_TAB, 1'b0);
        send_text("+/", 1'b0);
        send_char(CH_CR, 1'b0);
        send_char(CH_PAD, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CH_UA, 1'b1);
        // invalid char, then everything ignored with status held
        send_text("aZ", 1'b0);
        send_char(8'h00, 1'b0);
        send_char(CH_UA, 1'b0);
        send_char(CH_PAD, 1'b1);
        // leftover bits dropped at end of message
        send_text("0z9", 1'b1);
        // invalid char as the only, last char
        send_char(8'hFF, 1'b1);
        wait_for_results();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct <= 82;
                end
                1: begin
                    send_idle_pct = 82;
                    recv_idle_pct <= 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            while (chars_sent < 21 + (phase + 1) * 430) send_random_message();
            wait_for_results();
        end

        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && words_outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
